// File: sv/cit_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the compacting indexed table.
// Used by the interfaces, the entry cell and the top level.
package cit_pkg;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cit_cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } cit_status_e;

  localparam int unsigned IndexBits = 8;
  localparam int unsigned DataBits  = 32;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                 wr_en;   // legal write or append
    logic                 del_en;  // legal delete
    logic [IndexBits-1:0] idx;
  } cit_cell_ctrl_t;

endpackage

// File: sv/cit_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for commands and responses.
// Depends on cit_pkg for field widths.
interface cit_cmd_if
  import cit_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [1:0]           command;
  logic [IndexBits-1:0] index;
  logic [DataBits-1:0]  entry_data;

  modport source (output valid, command, index, entry_data, input ready);
  modport sink   (input valid, command, index, entry_data, output ready);
endinterface

interface cit_rsp_if
  import cit_pkg::*;
#(
  parameter int unsigned CNT_W = 5
) ();
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [DataBits-1:0] read_data;
  logic [CNT_W-1:0]    entry_count;

  modport source (output valid, status, read_data, entry_count, input ready);
  modport sink   (input valid, status, read_data, entry_count, output ready);
endinterface

// File: sv/compacting_indexed_table_unit.sv
`timescale 1ns / 1ps
// Compacting indexed table: a dense list of up to MAX_ENTRIES words held in a
// row of cells, with a fill count. Each command item gives one response item
// through an output register; a new item is taken while the response register
// is empty or being drained. Delete compacts as the item is taken: every cell
// at or above the index loads its upper neighbor.
// Read selects one cell through a mux on the index. Entry words wider than
// 32 bits are written zero-extended and read back truncated to 32 bits.
// Depends on cit_pkg, cit_if and cit_cell.
module compacting_indexed_table_unit
  import cit_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned ENTRY_BITS  = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cit_cmd_if.sink   cmd_i,
  cit_rsp_if.source rsp_o
);

  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
  localparam logic [IndexBits-1:0] MaxIdx = IndexBits'(MAX_ENTRIES);

  logic [CNT_W-1:0] count_d, count_q;
  logic             rsp_valid_d, rsp_valid_q;
  logic [1:0]       status_d, status_q;
  logic [DataBits-1:0] rdata_d, rdata_q;

  logic                  accept;
  cit_cmd_e              cmd;
  logic [IndexBits-1:0]  cnt_ext;
  logic                  in_range, at_end;
  cit_cell_ctrl_t        ctrl;
  logic [ENTRY_BITS-1:0] wr_data;
  logic [63:0]           wr_wide, rd_wide;
  logic [ENTRY_BITS-1:0] cells [MAX_ENTRIES];

  assign cmd_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign cmd         = cit_cmd_e'(cmd_i.command);
  assign cnt_ext     = IndexBits'(count_q);
  assign in_range    = cmd_i.index < cnt_ext;
  assign at_end      = cmd_i.index == cnt_ext;

  assign wr_wide = 64'(cmd_i.entry_data);
  assign wr_data = wr_wide[ENTRY_BITS-1:0];
  assign rd_wide = 64'(cells[cmd_i.index[IDX_W-1:0]]);

  assign ctrl.idx    = cmd_i.index;
  assign ctrl.wr_en  = accept && cmd == CMD_WRITE && (in_range || (at_end && cnt_ext < MaxIdx));
  assign ctrl.del_en = accept && cmd == CMD_DELETE && in_range;

  // Row of cells; the top cell keeps its own word on a delete.
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic [ENTRY_BITS-1:0] upper;
    if (g == MAX_ENTRIES - 1) begin : g_top
      assign upper = cells[g];
    end else begin : g_mid
      assign upper = cells[g+1];
    end
    cit_cell #(
      .ENTRY_BITS(ENTRY_BITS),
      .POS       (g)
    ) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .wr_data_i(wr_data),
      .upper_i  (upper),
      .entry_o  (cells[g])
    );
  end

  always_comb begin
    count_d     = count_q;
    rsp_valid_d = rsp_valid_q;
    status_d    = status_q;
    rdata_d     = rdata_q;
    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
    if (accept) begin
      rsp_valid_d = 1'b1;
      status_d    = ST_DONE;
      rdata_d     = '0;
      case (cmd)
        CMD_READ: begin
          if (in_range) begin
            rdata_d = rd_wide[DataBits-1:0];
          end else begin
            status_d = ST_RANGE;
          end
        end
        CMD_WRITE: begin
          if (!in_range) begin
            if (at_end) begin
              if (cnt_ext < MaxIdx) begin
                count_d = count_q + 1'b1;
              end else begin
                status_d = ST_FULL;
              end
            end else begin
              status_d = ST_RANGE;
            end
          end
        end
        CMD_DELETE: begin
          if (in_range) begin
            count_d = count_q - 1'b1;
          end else begin
            status_d = ST_RANGE;
          end
        end
        default: begin
          count_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    rdata_q  <= rdata_d;
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.read_data   = rdata_q;
  assign rsp_o.entry_count = count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    IndexBits'(count_q) <= MaxIdx)
    else $error("fill count above table depth");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd == CMD_CLEAR |=> count_q == '0 && rsp_o.status == ST_DONE)
    else $error("clear did not empty the table");

  a_delete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.del_en |=> count_q == $past(count_q) - 1'b1)
    else $error("delete did not drop the count by one");

  a_rsp_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> rsp_o.valid && rsp_o.entry_count == count_q)
    else $error("accepted item gave no response");

  a_fail_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status != ST_DONE |-> rsp_o.read_data == '0)
    else $error("failed command returned data");

endmodule

// File: sv/cit_cell.sv
`timescale 1ns / 1ps
// One entry slot of the table: loads on a write to its position and takes
// its upper neighbor's word on a delete at or below it. Depends on cit_pkg.
module cit_cell
  import cit_pkg::*;
#(
  parameter int unsigned ENTRY_BITS = 32,
  parameter int unsigned POS        = 0
) (
  input  logic                  clk_i,
  input  cit_cell_ctrl_t        ctrl_i,
  input  logic [ENTRY_BITS-1:0] wr_data_i,
  input  logic [ENTRY_BITS-1:0] upper_i,
  output logic [ENTRY_BITS-1:0] entry_o
);

  localparam logic [IndexBits-1:0] PosIdx = IndexBits'(POS);

  logic [ENTRY_BITS-1:0] entry_d, entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.wr_en && ctrl_i.idx == PosIdx) begin
      entry_d = wr_data_i;
    end else if (ctrl_i.del_en && PosIdx >= ctrl_i.idx) begin
      entry_d = upper_i;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// File: tb/cit_table_checker.sv
`timescale 1ns / 1ps
// Checker for the compacting indexed table: watches the command and response
// channels, keeps a shadow copy of the list and compares every response item.
// Depends on cit_pkg and the channel interfaces in cit_if.
module cit_table_checker
  import cit_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned CNT_W       = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cit_cmd_if          cmd_mon,
  cit_rsp_if          rsp_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    cit_status_e         status;
    logic [DataBits-1:0] read_data;
    logic [CNT_W-1:0]    entry_count;
  } table_reply_t;

  logic [DataBits-1:0] stored_words [MAX_ENTRIES];
  int unsigned         word_count;
  table_reply_t        replies_due [$];

  // Applies one command to the shadow list and returns the response it owes.
  function automatic table_reply_t apply_command(cit_cmd_e op, int unsigned idx,
                                                 logic [DataBits-1:0] data);
    table_reply_t reply;
    int unsigned  pos;
    reply.status    = ST_DONE;
    reply.read_data = '0;
    case (op)
      CMD_READ: begin
        if (idx < word_count) reply.read_data = stored_words[idx];
        else reply.status = ST_RANGE;
      end
      CMD_WRITE: begin
        if (idx < word_count) begin
          stored_words[idx] = data;
        end else if (idx == word_count) begin
          if (word_count < MAX_ENTRIES) begin
            stored_words[idx] = data;
            word_count++;
          end else begin
            reply.status = ST_FULL;
          end
        end else begin
          reply.status = ST_RANGE;
        end
      end
      CMD_DELETE: begin
        if (idx < word_count) begin
          // later entries close the gap
          for (pos = idx; pos + 1 < word_count; pos++)
            stored_words[pos] = stored_words[pos + 1];
          word_count--;
        end else begin
          reply.status = ST_RANGE;
        end
      end
      default: word_count = 0;
    endcase
    reply.entry_count = CNT_W'(word_count);
    return reply;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    table_reply_t due;
    if (!rst_ni) begin
      word_count   = 0;
      replies_due.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cmd_mon.valid && cmd_mon.ready)
        replies_due.push_back(apply_command(cit_cmd_e'(cmd_mon.command), cmd_mon.index,
                                            cmd_mon.entry_data));
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected item: status %0d read_data %h entry_count %0d",
                   $time, rsp_mon.status, rsp_mon.read_data, rsp_mon.entry_count);
          fail_count_o++;
        end else begin
          due = replies_due.pop_front();
          if (rsp_mon.status !== due.status) begin
            $display("%0t: status expected %0d, actual %0d",
                     $time, due.status, rsp_mon.status);
            fail_count_o++;
          end
          if (rsp_mon.read_data !== due.read_data) begin
            $display("%0t: read_data expected %h, actual %h",
                     $time, due.read_data, rsp_mon.read_data);
            fail_count_o++;
          end
          if (rsp_mon.entry_count !== due.entry_count) begin
            $display("%0t: entry_count expected %0d, actual %0d",
                     $time, due.entry_count, rsp_mon.entry_count);
            fail_count_o++;
          end
        end
      end
      pending_o = replies_due.size();
    end
  end

endmodule

// File: tb/tb_compacting_indexed_table_unit.sv
`timescale 1ns / 1ps
// Testbench top for the compacting indexed table: clock, reset, command and
// response traffic and the verdict. Depends on cit_pkg, cit_if, the unit and
// cit_table_checker.
module tb_compacting_indexed_table_unit;
  import cit_pkg::*;

  localparam int unsigned MaxEntries  = 16;
  localparam int unsigned CntW        = 5;
  localparam int unsigned RandomItems = 625;
  localparam int unsigned CalmItems   = 120;  // tail of the run with no idling
  localparam int unsigned HoldAfter   = 150;  // items sent before the long stall
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned DrainCycles = 8;

  logic        clk_i;
  logic        rst_ni;
  logic        idling_on;
  int unsigned items_sent;
  int unsigned live_count;
  int unsigned fail_count;
  int unsigned pending;

  cit_cmd_if                  cmd_ch ();
  cit_rsp_if #(.CNT_W(CntW)) rsp_ch ();

  compacting_indexed_table_unit #(
    .MAX_ENTRIES(MaxEntries),
    .ENTRY_BITS (DataBits)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_ch),
    .rsp_o (rsp_ch)
  );

  cit_table_checker #(
    .MAX_ENTRIES(MaxEntries),
    .CNT_W      (CntW)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_mon     (cmd_ch),
    .rsp_mon     (rsp_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb_compacting_indexed_table_unit failed");
    $finish;
  end

  // Offers one item, maybe after an idle burst, and returns once it is taken.
  task automatic send_item(input cit_cmd_e op, input logic [7:0] idx,
                           input logic [DataBits-1:0] data);
    int unsigned gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.command    <= op;
    cmd_ch.index      <= idx;
    cmd_ch.entry_data <= data;
    do @(posedge clk_i); while (!cmd_ch.ready);
    items_sent++;
    // fill level only, to aim indexes at the live region
    case (op)
      CMD_WRITE:  if (idx == live_count && live_count < MaxEntries) live_count++;
      CMD_DELETE: if (idx < live_count) live_count--;
      CMD_CLEAR:  live_count = 0;
      default: ;
    endcase
  endtask

  task automatic send_random_item();
    int unsigned         pick;
    int unsigned         aim;
    cit_cmd_e            op;
    logic [7:0]          idx;
    logic [DataBits-1:0] data;
    pick = $urandom_range(0, 99);
    if (pick < 28) op = CMD_READ;
    else if (pick < 70) op = CMD_WRITE;
    else if (pick < 99) op = CMD_DELETE;
    else op = CMD_CLEAR;
    aim = $urandom_range(0, 99);
    if (aim < 12) idx = 8'($urandom_range(0, 255));
    else if (aim < 50 || live_count == 0) idx = 8'(live_count);
    else idx = 8'($urandom_range(0, live_count - 1));
    case ($urandom_range(0, 7))
      0:       data = '0;
      1:       data = '1;
      default: data = $urandom();
    endcase
    send_item(op, idx, data);
  endtask

  initial begin : stimulus
    int unsigned n;
    cmd_ch.valid      <= 1'b0;
    cmd_ch.command    <= CMD_READ;
    cmd_ch.index      <= '0;
    cmd_ch.entry_data <= '0;
    rst_ni            <= 1'b0;
    idling_on  = 1'b1;
    items_sent = 0;
    live_count = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list: every indexed command is out of range
    send_item(CMD_READ, 8'd0, 32'h1234_5678);
    send_item(CMD_DELETE, 8'd0, '0);
    send_item(CMD_WRITE, 8'd3, 32'hDEAD_BEEF);
    // fill to the top, extreme data first
    send_item(CMD_WRITE, 8'd0, '1);
    send_item(CMD_WRITE, 8'd1, '0);
    for (n = 2; n < MaxEntries; n++) send_item(CMD_WRITE, 8'(n), $urandom());
    send_item(CMD_WRITE, 8'(MaxEntries), 32'hA5A5_5A5A);  // append when full
    send_item(CMD_READ, 8'(MaxEntries - 1), '0);
    send_item(CMD_DELETE, 8'd0, '1);                      // shifts every entry
    send_item(CMD_DELETE, 8'(MaxEntries - 2), '0);        // last entry
    send_item(CMD_WRITE, 8'd2, 32'h0F0F_F0F0);            // overwrite
    send_item(CMD_CLEAR, 8'hFF, '1);
    send_item(CMD_READ, 8'd0, '0);                        // stale after clear

    for (n = 0; n < RandomItems; n++) begin
      if (n == RandomItems - CalmItems) idling_on = 1'b0;
      send_random_item();
    end
    cmd_ch.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) $display("tb_compacting_indexed_table_unit passed");
    else $display("tb_compacting_indexed_table_unit failed");
    $finish;
  end

  initial begin : response_side
    bit          held;
    int unsigned span;
    held = 1'b0;
    rsp_ch.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && items_sent >= HoldAfter) begin
        // long stall so the unit backs up into its command side
        held = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (idling_on && $urandom_range(0, 2) == 0) begin
        span = $urandom_range(1, 17);
        rsp_ch.ready <= 1'b0;
        repeat (span) @(posedge clk_i);
      end else begin
        span = $urandom_range(1, 24);
        rsp_ch.ready <= 1'b1;
        repeat (span) @(posedge clk_i);
      end
    end
  end

endmodule

// File: files.f
sv/cit_pkg.sv
sv/cit_if.sv
sv/cit_cell.sv
sv/compacting_indexed_table_unit.sv
tb/cit_table_checker.sv
tb/tb_compacting_indexed_table_unit.sv
